@@ hdl/flpr_pkg.sv @@
// Package: request/result types and codes for the fault latch priority reporter.
`timescale 1ns / 1ps
`default_nettype none
package flpr_pkg;

  localparam int NUM_LATCH = 6;
  localparam int IDX_OV    = 0;
  localparam int IDX_UV    = 1;
  localparam int IDX_OC    = 2;
  localparam int IDX_OT    = 3;
  localparam int IDX_LINK1 = 4;
  localparam int IDX_LINK2 = 5;

  localparam logic [2:0] CMD_ELEC  = 3'd0;
  localparam logic [2:0] CMD_TEMP  = 3'd1;
  localparam logic [2:0] CMD_COMM  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [1:0] COMM_LINK1 = 2'd0;
  localparam logic [1:0] COMM_LINK2 = 2'd1;

  localparam logic [2:0] SRC_NONE = 3'd0;

  localparam logic [1:0] REG_OV_LIMIT = 2'd0;
  localparam logic [1:0] REG_UV_LIMIT = 2'd1;
  localparam logic [1:0] REG_OC_LIMIT = 2'd2;
  localparam logic [1:0] REG_OT_LIMIT = 2'd3;

  localparam logic [15:0] OV_LIMIT_RST = 16'd4200;
  localparam logic [15:0] UV_LIMIT_RST = 16'd3000;
  localparam logic [14:0] OC_LIMIT_RST = 15'd20000;
  localparam logic [7:0]  OT_LIMIT_RST = 8'd190;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [15:0]        voltage_mv;
    logic signed [15:0] current_raw;
    logic [7:0]         temp_code;
    logic [1:0]         comm_source;
    logic               comm_active;
    logic [7:0]         error_code;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  fault_source;
    logic        fault_severity;
    logic [15:0] fault_value;
  } out_res_t;

endpackage
`default_nettype wire

@@ hdl/flpr_select.sv @@
// Priority selection of the highest active fault latch.
`timescale 1ns / 1ps
`default_nettype none
module flpr_select (
  input  wire logic [5:0]       act,
  input  wire logic [5:0][15:0] val,
  output flpr_pkg::out_res_t    pick
);
  import flpr_pkg::*;

  always_comb begin
    pick = '0;
    pick.fault_source = SRC_NONE;
    // lowest index wins: scan from the bottom of the order up
    for (int i = NUM_LATCH - 1; i >= 0; i--) begin
      if (act[i]) begin
        pick.fault_source   = 3'(i + 1);
        pick.fault_severity = (i <= IDX_OC);
        pick.fault_value    = val[i];
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/fault_latch_priority_reporter_core.sv @@
// Top level: fault latches, change-only reporting and output skid stage.
//
//  channel | dir | handshake         | payload
//  in_     | in  | in_valid/in_stall | in_req  (flpr_pkg::in_req_t)
//  out_    | out | out_valid/out_stall| out_res (flpr_pkg::out_res_t)
//  cfg_    | in  | cfg_we            | cfg_addr, cfg_wdata
//
// One request per cycle unless in_stall; latch update and tick selection are
// one pass from the latch registers to the result register (or the skid register
// while it is held). A two-entry output stage (result + skid) keeps requests
// flowing while a report waits; in_stall rises only when the skid is full.
// Reset (synchronous) clears latches, sent record, limits to defaults, out_valid.
`timescale 1ns / 1ps
`default_nettype none
module fault_latch_priority_reporter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire flpr_pkg::in_req_t  in_req,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output flpr_pkg::out_res_t      out_res,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_addr,
  input  wire logic [15:0]        cfg_wdata
);
  import flpr_pkg::*;

  logic [15:0] ov_limit_r, uv_limit_r;
  logic [14:0] oc_limit_r;
  logic [7:0]  ot_limit_r;

  logic [5:0]       act_r, act_nxt;
  logic [5:0][15:0] val_r, val_nxt;

  logic        sent_valid_r;
  logic [2:0]  sent_source_r;
  logic [15:0] sent_value_r;

  logic     out_valid_r, skid_valid_r;
  out_res_t out_res_r, skid_res_r;

  logic     in_acc, is_tick, emit, out_pop;
  logic     ov_hit, uv_hit, oc_hit, ot_hit;
  out_res_t pick;

  flpr_select u_select (
    .act  (act_r),
    .val  (val_r),
    .pick (pick)
  );

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_pop   = out_valid_r && !out_stall;

  assign ov_hit = in_req.voltage_mv > ov_limit_r;
  assign uv_hit = !ov_hit && (in_req.voltage_mv < uv_limit_r);
  assign oc_hit = !in_req.current_raw[15] && (in_req.current_raw[14:0] > oc_limit_r);
  assign ot_hit = in_req.temp_code > ot_limit_r;

  assign is_tick = in_acc && (in_req.cmd == CMD_TICK);
  assign emit    = is_tick && !(sent_valid_r && pick.fault_source == sent_source_r &&
                                pick.fault_value == sent_value_r);

  always_comb begin
    act_nxt = act_r;
    val_nxt = val_r;
    if (in_acc) begin
      unique case (in_req.cmd)
        CMD_ELEC: begin
          act_nxt[IDX_OV] = ov_hit;
          val_nxt[IDX_OV] = ov_hit ? in_req.voltage_mv : 16'd0;
          act_nxt[IDX_UV] = uv_hit;
          val_nxt[IDX_UV] = uv_hit ? in_req.voltage_mv : 16'd0;
          act_nxt[IDX_OC] = oc_hit;
          val_nxt[IDX_OC] = oc_hit ? 16'(in_req.current_raw) : 16'd0;
        end
        CMD_TEMP: begin
          act_nxt[IDX_OT] = ot_hit;
          val_nxt[IDX_OT] = ot_hit ? {8'd0, in_req.temp_code} : 16'd0;
        end
        CMD_COMM: begin
          if (in_req.comm_source == COMM_LINK1) begin
            act_nxt[IDX_LINK1] = in_req.comm_active;
            val_nxt[IDX_LINK1] = in_req.comm_active ? {8'd0, in_req.error_code} : 16'd0;
          end else if (in_req.comm_source == COMM_LINK2) begin
            act_nxt[IDX_LINK2] = in_req.comm_active;
            val_nxt[IDX_LINK2] = in_req.comm_active ? {8'd0, in_req.error_code} : 16'd0;
          end
        end
        CMD_CLEAR: begin
          act_nxt = '0;
          val_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_limit_r <= OV_LIMIT_RST;
      uv_limit_r <= UV_LIMIT_RST;
      oc_limit_r <= OC_LIMIT_RST;
      ot_limit_r <= OT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OV_LIMIT: ov_limit_r <= cfg_wdata;
        REG_UV_LIMIT: uv_limit_r <= cfg_wdata;
        REG_OC_LIMIT: oc_limit_r <= cfg_wdata[14:0];
        REG_OT_LIMIT: ot_limit_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r         <= '0;
      val_r         <= '0;
      sent_valid_r  <= 1'b0;
      sent_source_r <= SRC_NONE;
      sent_value_r  <= '0;
    end else begin
      act_r <= act_nxt;
      val_r <= val_nxt;
      if (emit) begin
        sent_valid_r  <= 1'b1;
        sent_source_r <= pick.fault_source;
        sent_value_r  <= pick.fault_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_pop) begin
      out_valid_r <= emit;
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_res_r <= skid_res_r;
      end
    end else if (!out_valid_r || out_pop) begin
      if (emit) begin
        out_res_r <= pick;
      end
    end else if (emit) begin
      skid_res_r <= pick;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a result while the output register is empty");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("report lost after a changed tick");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_req.cmd == CMD_CLEAR |=> act_r == '0 && val_r == '0)
    else $error("latches not cleared");

  a_sent_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> sent_valid_r && sent_source_r == $past(pick.fault_source))
    else $error("sent record not updated on report");

  a_no_emit_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
    is_tick && sent_valid_r && pick.fault_source == sent_source_r &&
    pick.fault_value == sent_value_r |-> !emit)
    else $error("repeated report of unchanged fault");

endmodule
`default_nettype wire

@@ tb/sv/fault_latch_priority_reporter_core_test.sv @@
// Self-checking testbench for the fault latch priority reporter core.
`timescale 1ns / 1ps
module fault_latch_priority_reporter_core_test;
  import flpr_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam logic [1:0] COMM_IGN_LO = 2'd2;
  localparam logic [1:0] COMM_IGN_HI = 2'd3;
  localparam logic [2:0] SRC_OV      = 3'd1;
  localparam logic [2:0] SRC_UV      = 3'd2;
  localparam logic [2:0] SRC_OC      = 3'd3;
  localparam logic [2:0] SRC_OT      = 3'd4;
  localparam logic [2:0] SRC_LINK1   = 3'd5;
  localparam logic [2:0] SRC_LINK2   = 3'd6;
  localparam logic       SEV_WARN    = 1'b0;
  localparam logic       SEV_PROT    = 1'b1;
  localparam int         RAND_PHASES = 8;
  localparam int         PHASE_ITEMS = 190;
  localparam int         HOLD_CYCLES = 80;
  localparam int         IDLE_LIMIT  = 1000;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_res_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_req = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_res_t    out_res;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_OV_LIMIT;
  logic [15:0] cfg_wdata = '0;

  // predictor state
  logic [15:0] lim_ov = OV_LIMIT_RST;
  logic [15:0] lim_uv = UV_LIMIT_RST;
  logic [14:0] lim_oc = OC_LIMIT_RST;
  logic [7:0]  lim_ot = OT_LIMIT_RST;
  logic        latch_on [NUM_LATCH];
  logic [15:0] latch_val [NUM_LATCH];
  bit          sent_any = 1'b0;
  logic [2:0]  sent_src = SRC_NONE;
  logic [15:0] sent_val = '0;

  out_res_t    report_q [$];
  row_t        dir_tab [$];
  bit          row_typed = 1'b0;
  out_res_t    row_res = '0;
  bit          quiet = 1'b0;
  bit          press = 1'b0;
  bit          hold_req = 1'b0;
  int          fails = 0;
  int          idle_cycles = 0;

  fault_latch_priority_reporter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_LATCH; i++) begin
      latch_on[i] = 1'b0;
      latch_val[i] = '0;
    end
  end

  function automatic void set_latch(input int idx, input logic on, input logic [15:0] val);
    latch_on[idx] = on;
    latch_val[idx] = on ? val : 16'h0000;
  endfunction

  // Applies one request to the latch model; returns 1 when a tick reports.
  function automatic bit apply_request(input in_req_t r, output out_res_t rep);
    logic ov_hit;
    int   pick;
    rep = '0;
    pick = -1;
    case (r.cmd)
      CMD_ELEC: begin
        ov_hit = r.voltage_mv > lim_ov;
        set_latch(IDX_OV, ov_hit, r.voltage_mv);
        set_latch(IDX_UV, !ov_hit && (r.voltage_mv < lim_uv), r.voltage_mv);
        set_latch(IDX_OC, $signed(r.current_raw) > $signed({1'b0, lim_oc}), r.current_raw);
      end
      CMD_TEMP: set_latch(IDX_OT, r.temp_code > lim_ot, {8'h00, r.temp_code});
      CMD_COMM: begin
        if (r.comm_source == COMM_LINK1) begin
          set_latch(IDX_LINK1, r.comm_active, {8'h00, r.error_code});
        end else if (r.comm_source == COMM_LINK2) begin
          set_latch(IDX_LINK2, r.comm_active, {8'h00, r.error_code});
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NUM_LATCH; i++) set_latch(i, 1'b0, 16'h0000);
      end
      CMD_TICK: begin
        for (int i = NUM_LATCH - 1; i >= 0; i--) if (latch_on[i]) pick = i;
        if (pick >= 0) begin
          rep.fault_source = 3'(pick + 1);
          rep.fault_severity = (pick <= IDX_OC) ? SEV_PROT : SEV_WARN;
          rep.fault_value = latch_val[pick];
        end
        if (sent_any && rep.fault_source == sent_src && rep.fault_value == sent_val) return 1'b0;
        sent_any = 1'b1;
        sent_src = rep.fault_source;
        sent_val = rep.fault_value;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic in_req_t rand_req();
    in_req_t r;
    int      sel;
    r.voltage_mv = 16'($urandom);
    r.current_raw = 16'($urandom);
    r.temp_code = 8'($urandom);
    r.comm_source = 2'($urandom);
    r.comm_active = 1'($urandom);
    r.error_code = 8'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 25) r.cmd = CMD_ELEC;
    else if (sel < 40) r.cmd = CMD_TEMP;
    else if (sel < 60) r.cmd = CMD_COMM;
    else if (sel < 64) r.cmd = CMD_CLEAR;
    else if (sel < 95) r.cmd = CMD_TICK;
    else r.cmd = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    // pull values toward the thresholds so latches flip often
    case ($urandom_range(0, 3))
      0: r.voltage_mv = lim_ov + 16'($urandom_range(0, 4)) - 16'd2;
      1: r.voltage_mv = lim_uv + 16'($urandom_range(0, 4)) - 16'd2;
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0)
      r.current_raw = {1'b0, lim_oc} + 16'($urandom_range(0, 4)) - 16'd2;
    if ($urandom_range(0, 2) == 0)
      r.temp_code = lim_ot + 8'($urandom_range(0, 4)) - 8'd2;
    if ($urandom_range(0, 4) != 0)
      r.comm_source = $urandom_range(0, 1) ? COMM_LINK2 : COMM_LINK1;
    return r;
  endfunction

  task automatic add_row(input logic [2:0] cmd, input logic [15:0] volt, input logic [15:0] cur,
                         input logic [7:0] temp, input logic [1:0] src, input logic act,
                         input logic [7:0] code, input bit typed, input logic [2:0] esrc,
                         input logic esev, input logic [15:0] eval);
    row_t row;
    row.req = '{cmd, volt, cur, temp, src, act, code};
    row.typed = typed;
    row.res = '{esrc, esev, eval};
    dir_tab.push_back(row);
  endtask

  // Called just after a falling edge; returns just after the falling edge
  // that follows acceptance, with in_valid still high.
  task automatic send_req(input in_req_t r, input bit typed, input out_res_t tres);
    int gap;
    gap = (quiet || press) ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    row_typed = typed;
    row_res = tres;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_reports();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limits(input logic [15:0] ov, input logic [15:0] uv,
                              input logic [15:0] oc, input logic [15:0] ot);
    cfg_we <= 1'b1;
    cfg_addr <= REG_OV_LIMIT;
    cfg_wdata <= ov;
    @(negedge clk);
    cfg_addr <= REG_UV_LIMIT;
    cfg_wdata <= uv;
    @(negedge clk);
    cfg_addr <= REG_OC_LIMIT;
    cfg_wdata <= oc;
    @(negedge clk);
    cfg_addr <= REG_OT_LIMIT;
    cfg_wdata <= ot;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : watch
    bit       has;
    out_res_t got;
    out_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("unexpected report: source %0d severity %0d value %0d",
                 out_res.fault_source, out_res.fault_severity, out_res.fault_value);
          fails++;
        end else begin
          want = report_q.pop_front();
          if (out_res.fault_source !== want.fault_source) begin
            $error("fault_source: expected %0d, got %0d", want.fault_source, out_res.fault_source);
            fails++;
          end
          if (out_res.fault_severity !== want.fault_severity) begin
            $error("fault_severity: expected %0d, got %0d",
                   want.fault_severity, out_res.fault_severity);
            fails++;
          end
          if (out_res.fault_value !== want.fault_value) begin
            $error("fault_value: expected %0d, got %0d", want.fault_value, out_res.fault_value);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_OV_LIMIT: lim_ov = cfg_wdata;
          REG_UV_LIMIT: lim_uv = cfg_wdata;
          REG_OC_LIMIT: lim_oc = cfg_wdata[14:0];
          REG_OT_LIMIT: lim_ot = cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        has = apply_request(in_req, got);
        if (row_typed) report_q.push_back(row_res);
        else if (has) report_q.push_back(got);
      end
    end
  end

  // result side: random stall after each report, plus one long hold-off
  initial begin : receiver
    int hold_left;
    int gap_left;
    bit took;
    hold_left = 0;
    gap_left = 0;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (took) gap_left = quiet ? 0 : $urandom_range(0, 5);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("fault_latch_priority_reporter_core: mismatch");
      $finish;
    end
  end

  initial begin : main
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, default limits
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_ELEC, 16'hFFFF, 16'h7FFF, 8'hFF, COMM_LINK1, 1'b0, 8'd0,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_OV, SEV_PROT, 16'hFFFF);
    add_row(CMD_ELEC, 16'd0, 16'h8000, 8'd0, COMM_LINK1, 1'b0, 8'd0,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_UV, SEV_PROT, 16'd0);
    add_row(CMD_ELEC, 16'd3500, 16'd20001, 8'd0, COMM_LINK1, 1'b0, 8'd0,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_OC, SEV_PROT, 16'd20001);
    add_row(CMD_ELEC, 16'd3500, 16'd20000, 8'd0, COMM_LINK1, 1'b0, 8'd0,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TEMP, 16'd0, 16'd0, 8'd255, COMM_LINK1, 1'b0, 8'd0, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_OT, SEV_WARN, 16'd255);
    add_row(CMD_TEMP, 16'd0, 16'd0, 8'd190, COMM_LINK1, 1'b0, 8'd0, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_COMM, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b1, 8'hFF, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_COMM, 16'd0, 16'd0, 8'd0, COMM_LINK2, 1'b1, 8'h00, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_LINK1, SEV_WARN, 16'd255);
    add_row(CMD_COMM, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'hAB, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_LINK2, SEV_WARN, 16'd0);
    add_row(CMD_COMM, 16'd0, 16'd0, 8'd0, COMM_IGN_LO, 1'b1, 8'h55, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_COMM, 16'd0, 16'd0, 8'd0, COMM_IGN_HI, 1'b0, 8'hAA, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_RSVD_LO, 16'hFFFF, 16'h7FFF, 8'hFF, COMM_LINK1, 1'b1, 8'hFF,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_RSVD_HI, 16'd0, 16'h8000, 8'hFF, COMM_LINK2, 1'b1, 8'h0F,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_ELEC, 16'd4201, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0,
            0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_CLEAR, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 0, SRC_NONE, SEV_WARN, 16'd0);
    add_row(CMD_TICK, 16'd0, 16'd0, 8'd0, COMM_LINK1, 1'b0, 8'd0, 1, SRC_NONE, SEV_WARN, 16'd0);
    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);

    // random part, one limit setting per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_reports();
      case (ph)
        0: write_limits(OV_LIMIT_RST, UV_LIMIT_RST, 16'(OC_LIMIT_RST), 16'(OT_LIMIT_RST));
        1: write_limits(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        2: write_limits(16'hFFFF, 16'h0000, 16'h7FFF, 16'h00FF);
        3: write_limits(16'd100, 16'd60000, 16'hFFFF, 16'hFF80);
        default: write_limits(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        press = (ph == 2) && (k >= 20) && (k < 110);
        if (ph == 2 && k == 20) hold_req = 1'b1;
        send_req(rand_req(), 1'b0, '0);
      end
      press = 1'b0;
    end

    drain_reports();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("fault_latch_priority_reporter_core: match");
    end else begin
      $display("fault_latch_priority_reporter_core: mismatch");
    end
    $finish;
  end

endmodule
